@@ rtl/core/bfa_pkg.sv @@
// Shared types, codes and constants of the buddy frame allocator.
`default_nettype none
package bfa_pkg;

    localparam int FRAME_W   = 20;
    localparam int CNT_W     = 15;
    localparam int AW        = FRAME_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_NUM_ORDERS = 11;
    localparam int DEF_MAX_FRAMES = 16384;

    typedef enum logic [1:0] {
        FN_ALLOC    = 2'd0,
        FN_FREE     = 2'd1,
        FN_ALLOC_AT = 2'd2,
        FN_INIT     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_MEM   = 2'd2,
        ST_TAKEN    = 2'd3
    } rsp_status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = CFG_IDX_W'(1);

    typedef struct packed {
        func_t              func;
        logic [FRAME_W-1:0] frame;
        logic [CNT_W-1:0]   nframes;
    } bfa_req_t;

    typedef struct packed {
        rsp_status_t        status;
        logic [FRAME_W-1:0] frame_out;
        logic [CNT_W-1:0]   free_cnt;
    } bfa_rsp_t;

    typedef struct packed {
        logic rd;
        logic nx_we;
        logic pv_we;
    } link_ctl_t;

    typedef struct packed {
        logic rd;
        logic we;
        logic wdata;
        logic clr;
    } bm_ctl_t;

    // start of the bitmap section that holds blocks of order ord
    function automatic int bit_off(input int ord, input int max_frames);
        int off;
        off = 0;
        for (int j = 0; j < ord; j++)
        begin
            off = off + (max_frames >> j) + 1;
        end
        return off;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/bfa_links.sv @@
// Next and prev link memories of the free lists.
`default_nettype none
module bfa_links #(
    parameter int MAX_FRAMES = 16384
) (
    input  wire                             clk,
    input  bfa_pkg::link_ctl_t              ctl,
    input  wire [$clog2(MAX_FRAMES)-1:0]    rd_addr,
    input  wire [$clog2(MAX_FRAMES)-1:0]    nx_addr,
    input  wire [$clog2(MAX_FRAMES):0]      nx_wdata,
    input  wire [$clog2(MAX_FRAMES)-1:0]    pv_addr,
    input  wire [$clog2(MAX_FRAMES):0]      pv_wdata,
    output logic [$clog2(MAX_FRAMES):0]     nx_q,
    output logic [$clog2(MAX_FRAMES):0]     pv_q
);
    import bfa_pkg::*;

    localparam int LW = $clog2(MAX_FRAMES) + 1;

    logic [LW-1:0] next_mem [MAX_FRAMES];
    logic [LW-1:0] prev_mem [MAX_FRAMES];
    logic [LW-1:0] nx_q_reg;
    logic [LW-1:0] pv_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.nx_we)
        begin
            next_mem[nx_addr] <= nx_wdata;
        end
        if (ctl.rd)
        begin
            nx_q_reg <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pv_we)
        begin
            prev_mem[pv_addr] <= pv_wdata;
        end
        if (ctl.rd)
        begin
            pv_q_reg <= prev_mem[rd_addr];
        end
    end

    assign nx_q = nx_q_reg;
    assign pv_q = pv_q_reg;

endmodule
`default_nettype wire

@@ rtl/core/bfa_bitmap.sv @@
// Per-order free bitmap with a clearing sweep after reset and on request.
`default_nettype none
module bfa_bitmap #(
    parameter int NUM_ORDERS = 11,
    parameter int MAX_FRAMES = 16384
) (
    input  wire                                           clk,
    input  wire                                           rst_n,
    input  bfa_pkg::bm_ctl_t                              ctl,
    input  wire [$clog2(2*MAX_FRAMES+NUM_ORDERS)-1:0]     addr,
    output logic                                          q,
    output logic                                          busy
);
    import bfa_pkg::*;

    localparam int BS = 2 * MAX_FRAMES + NUM_ORDERS;
    localparam int BW = $clog2(BS);

    logic          bit_mem [BS];
    logic          q_reg;
    logic          active_reg;
    logic [BW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (ctl.clr)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (active_reg)
        begin
            if (cnt_reg == BW'(BS - 1))
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + BW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (active_reg)
        begin
            bit_mem[cnt_reg] <= 1'b0;
        end
        else if (ctl.we)
        begin
            bit_mem[addr] <= ctl.wdata;
        end
        if (ctl.rd)
        begin
            q_reg <= bit_mem[addr];
        end
    end

    assign q    = q_reg;
    assign busy = active_reg;

endmodule
`default_nettype wire

@@ rtl/core/bfa_seq.sv @@
// Sequencer: alloc, free range, carve and init over the list and bitmap memories.
`default_nettype none
module bfa_seq #(
    parameter int NUM_ORDERS = 11,
    parameter int MAX_FRAMES = 16384
) (
    input  wire                                           clk,
    input  wire                                           rst_n,
    input  wire                                           in_valid,
    output logic                                          in_stall,
    input  bfa_pkg::bfa_req_t                             in_data,
    output logic                                          out_valid,
    input  wire                                           out_stall,
    output bfa_pkg::bfa_rsp_t                             out_data,
    input  wire                                           cfg_valid,
    output logic                                          cfg_ready,
    input  wire [bfa_pkg::CFG_IDX_W-1:0]                  cfg_index,
    input  wire [bfa_pkg::FRAME_W-1:0]                    cfg_data,
    output bfa_pkg::link_ctl_t                            lk_ctl,
    output logic [$clog2(MAX_FRAMES)-1:0]                 lk_rd_addr,
    output logic [$clog2(MAX_FRAMES)-1:0]                 lk_nx_addr,
    output logic [$clog2(MAX_FRAMES):0]                   lk_nx_wdata,
    output logic [$clog2(MAX_FRAMES)-1:0]                 lk_pv_addr,
    output logic [$clog2(MAX_FRAMES):0]                   lk_pv_wdata,
    input  wire [$clog2(MAX_FRAMES):0]                    lk_nx_q,
    input  wire [$clog2(MAX_FRAMES):0]                    lk_pv_q,
    output bfa_pkg::bm_ctl_t                              bm_ctl,
    output logic [$clog2(2*MAX_FRAMES+NUM_ORDERS)-1:0]    bm_addr,
    input  wire                                           bm_q,
    input  wire                                           bm_busy
);
    import bfa_pkg::*;

    localparam int IW  = $clog2(MAX_FRAMES);
    localparam int LW  = IW + 1;
    localparam int BS  = 2 * MAX_FRAMES + NUM_ORDERS;
    localparam int BW  = $clog2(BS);
    localparam int OW  = $clog2(NUM_ORDERS);
    localparam int OW1 = $clog2(NUM_ORDERS + 1);

    localparam logic [OW-1:0] TOP_ORD = OW'(NUM_ORDERS - 1);
    localparam logic [LW-1:0] NIL     = LW'(MAX_FRAMES);
    localparam logic [AW-1:0] MAX_A   = AW'(MAX_FRAMES);

    typedef enum logic [4:0] {
        S_IDLE, S_AL_START, S_AL_FIND, S_AL_CLR, S_AL_SPLIT, S_AL_SPLB, S_AL_END,
        S_FR_TOP, S_FR_SCAN, S_FR_NEXT,
        S_CV_TOP, S_CV_FIND, S_CV_CHK, S_CV_CLR, S_CV_SPLIT,
        S_IN_CLR, S_IN_WAIT, S_IN_TOP, S_IN_NEXT,
        S_FB_TOP, S_FB_CHK, S_FB_MRG, S_FB_PUSH, S_FB_SET,
        S_LR_RD, S_LR_WR, S_LP_WR, S_LP_LINK, S_DONE
    } state_t;

    state_t state_reg, ret_lst_reg, ret_fb_reg, ret_fr_reg;

    logic [FRAME_W-1:0] base_reg;
    logic [CNT_W-1:0]   frames_reg;

    logic [CNT_W-1:0]   nreq_reg;
    logic [FRAME_W-1:0] r_reg;
    rsp_status_t        status_reg;
    logic [FRAME_W-1:0] fout_reg;

    logic [OW-1:0]      ord_need_reg;
    logic [OW1-1:0]     f_reg;
    logic [AW-1:0]      a_reg;

    logic [AW-1:0]      fr_r_reg;
    logic [CNT_W-1:0]   fr_n_reg;
    logic [OW-1:0]      c_reg;
    logic [AW-1:0]      i_reg;
    logic [OW-1:0]      k_reg;
    logic               pend_reg;
    logic               last_reg;

    logic [CNT_W-1:0]   cv_i_reg;
    logic [AW-1:0]      cr_reg;
    logic [OW-1:0]      cv_o_reg;
    logic [AW-1:0]      base_blk_reg;

    logic [AW-1:0]      fb_r_reg;
    logic [OW-1:0]      fb_o_reg;

    logic [OW-1:0]      lst_ord_reg;
    logic [IW-1:0]      lst_n_reg;

    logic [LW-1:0]      head_reg  [NUM_ORDERS];
    logic [CNT_W-1:0]   count_reg [NUM_ORDERS];
    logic [CNT_W-1:0]   total_reg;

    logic               rdok_reg;
    logic               out_valid_reg;
    bfa_rsp_t           out_data_reg;

    logic [BW-1:0]      off_tab [NUM_ORDERS];

    for (genvar g = 0; g < NUM_ORDERS; g++)
    begin : g_off
        assign off_tab[g] = BW'(bit_off(g, MAX_FRAMES));
    end

    // combinational helpers
    logic [AW-1:0]   lim;
    logic [OW-1:0]   al_ord;
    logic            al_bad;
    logic [OW-1:0]   fr_c;
    logic [OW-1:0]   in_o;
    logic [AW-1:0]   fr_sz;
    logic [AW-1:0]   fr_cur;
    logic [AW-1:0]   fb_one;
    logic [AW-1:0]   fb_bidx;
    logic [AW-1:0]   fb_b;
    logic [AW-1:0]   cv_idx;
    logic [AW-1:0]   cv_base;
    logic [OW-1:0]   cv_o_dn;
    logic [AW-1:0]   cv_upper;
    logic [OW-1:0]   f_dn;
    logic [AW-1:0]   al_s_push;
    logic [AW-1:0]   al_s_set;
    logic [AW-1:0]   lst_one;
    logic [OW-1:0]   hsel;
    logic [LW-1:0]   head_q;
    logic [CNT_W-1:0] count_q;
    logic            bit_q;
    logic            scan_issue;
    logic [OW-1:0]   bm_ord;
    logic [AW-1:0]   bm_idx;
    logic [AW:0]     bm_pos;
    logic            bm_rng;
    logic            in_acc;

    assign lim = (AW'(frames_reg) > MAX_A) ? MAX_A : AW'(frames_reg);

    always_comb
    begin
        al_ord = TOP_ORD;
        for (int j = NUM_ORDERS - 1; j >= 0; j--)
        begin
            if ((AW'(1) << j) >= AW'(nreq_reg))
            begin
                al_ord = OW'(j);
            end
        end
        al_bad = (nreq_reg == '0) || (AW'(nreq_reg) > (AW'(1) << (NUM_ORDERS - 1)));
    end

    // largest aligned chunk that fits the remaining count, and the largest that fits below the region limit
    always_comb
    begin
        fr_c = '0;
        in_o = '0;
        for (int j = 1; j < NUM_ORDERS; j++)
        begin
            if ((fr_r_reg & ((AW'(1) << j) - AW'(1))) == '0)
            begin
                if ((AW'(1) << j) <= AW'(fr_n_reg))
                begin
                    fr_c = OW'(j);
                end
                if ((AW'(1) << j) <= lim && fr_r_reg <= lim - (AW'(1) << j))
                begin
                    in_o = OW'(j);
                end
            end
        end
    end

    assign fr_sz     = AW'(1) << c_reg;
    assign fr_cur    = fr_r_reg + i_reg;
    assign fb_one    = AW'(1) << fb_o_reg;
    assign fb_bidx   = (fb_r_reg >> fb_o_reg) ^ AW'(1);
    assign fb_b      = fb_bidx << fb_o_reg;
    assign cv_idx    = cr_reg >> cv_o_reg;
    assign cv_base   = cv_idx << cv_o_reg;
    assign cv_o_dn   = cv_o_reg - OW'(1);
    assign cv_upper  = base_blk_reg + (AW'(1) << cv_o_dn);
    assign f_dn      = OW'(f_reg - OW1'(1));
    assign al_s_push = a_reg + (AW'(1) << f_dn);
    assign al_s_set  = a_reg + (AW'(1) << f_reg);
    assign lst_one   = AW'(1) << lst_ord_reg;
    assign hsel      = (state_reg == S_AL_FIND) ? OW'(f_reg) : lst_ord_reg;
    assign head_q    = head_reg[hsel];
    assign count_q   = count_reg[hsel];
    assign bit_q     = bm_q & rdok_reg;
    assign scan_issue = !(pend_reg && bit_q) && !last_reg;
    assign in_acc    = in_valid && !in_stall;

    // memory port control
    always_comb
    begin
        lk_ctl      = '0;
        lk_rd_addr  = lst_n_reg;
        lk_nx_addr  = lst_n_reg;
        lk_nx_wdata = head_q;
        lk_pv_addr  = lst_n_reg;
        lk_pv_wdata = NIL;
        bm_ctl      = '0;
        bm_ord      = fb_o_reg;
        bm_idx      = fb_bidx;
        unique case (state_reg)
            S_LR_RD:
            begin
                lk_ctl.rd = 1'b1;
            end
            S_LR_WR:
            begin
                lk_ctl.nx_we = (lk_pv_q < NIL);
                lk_nx_addr   = lk_pv_q[IW-1:0];
                lk_nx_wdata  = lk_nx_q;
                lk_ctl.pv_we = (lk_nx_q < NIL);
                lk_pv_addr   = lk_nx_q[IW-1:0];
                lk_pv_wdata  = lk_pv_q;
            end
            S_LP_WR:
            begin
                lk_ctl.nx_we = 1'b1;
                lk_ctl.pv_we = 1'b1;
            end
            S_LP_LINK:
            begin
                lk_ctl.pv_we = (head_q < NIL);
                lk_pv_addr   = head_q[IW-1:0];
                lk_pv_wdata  = LW'(lst_n_reg);
            end
            S_FB_TOP:
            begin
                bm_ctl.rd = (fb_o_reg < TOP_ORD) &&
                            ((AW+1)'(fb_b) + (AW+1)'(fb_one) <= (AW+1)'(lim));
            end
            S_FB_MRG:
            begin
                bm_ctl.we = 1'b1;
            end
            S_FB_SET:
            begin
                bm_ctl.we    = 1'b1;
                bm_ctl.wdata = 1'b1;
                bm_idx       = fb_r_reg >> fb_o_reg;
            end
            S_FR_SCAN:
            begin
                bm_ctl.rd = scan_issue;
                bm_ord    = k_reg;
                bm_idx    = fr_cur >> k_reg;
            end
            S_CV_FIND:
            begin
                bm_ctl.rd = 1'b1;
                bm_ord    = cv_o_reg;
                bm_idx    = cv_idx;
            end
            S_CV_CLR:
            begin
                bm_ctl.we = 1'b1;
                bm_ord    = cv_o_reg;
                bm_idx    = cv_idx;
            end
            S_AL_CLR:
            begin
                bm_ctl.we = 1'b1;
                bm_ord    = OW'(f_reg);
                bm_idx    = a_reg >> f_reg;
            end
            S_AL_SPLB:
            begin
                bm_ctl.we    = 1'b1;
                bm_ctl.wdata = 1'b1;
                bm_ord       = OW'(f_reg);
                bm_idx       = al_s_set >> f_reg;
            end
            S_IN_CLR:
            begin
                bm_ctl.clr = 1'b1;
            end
            default:
            begin
                bm_ctl = '0;
            end
        endcase
        bm_pos = (AW+1)'(off_tab[bm_ord]) + (AW+1)'(bm_idx);
        bm_rng = bm_pos < (AW+1)'(BS);
        bm_addr = bm_pos[BW-1:0];
        bm_ctl.rd = bm_ctl.rd && bm_rng;
        bm_ctl.we = bm_ctl.we && bm_rng;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_lst_reg   <= S_IDLE;
            ret_fb_reg    <= S_IDLE;
            ret_fr_reg    <= S_IDLE;
            base_reg      <= '0;
            frames_reg    <= CNT_W'(16384);
            nreq_reg      <= '0;
            r_reg         <= '0;
            status_reg    <= ST_OK;
            fout_reg      <= '0;
            ord_need_reg  <= '0;
            f_reg         <= '0;
            a_reg         <= '0;
            fr_r_reg      <= '0;
            fr_n_reg      <= '0;
            c_reg         <= '0;
            i_reg         <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            last_reg      <= 1'b0;
            cv_i_reg      <= '0;
            cr_reg        <= '0;
            cv_o_reg      <= '0;
            base_blk_reg  <= '0;
            fb_r_reg      <= '0;
            fb_o_reg      <= '0;
            lst_ord_reg   <= '0;
            lst_n_reg     <= '0;
            for (int j = 0; j < NUM_ORDERS; j++)
            begin
                head_reg[j]  <= NIL;
                count_reg[j] <= '0;
            end
            total_reg     <= '0;
            rdok_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else if (cfg_index == CFG_FRAMES)
                begin
                    frames_reg <= cfg_data[CNT_W-1:0];
                end
            end

            if (bm_ctl.rd)
            begin
                rdok_reg <= bm_rng;
            end

            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        nreq_reg   <= in_data.nframes;
                        r_reg      <= in_data.frame - base_reg;
                        fout_reg   <= in_data.frame;
                        status_reg <= ST_OK;
                        unique case (in_data.func)
                            FN_ALLOC:
                            begin
                                state_reg <= S_AL_START;
                            end
                            FN_FREE:
                            begin
                                // offset wraps at the frame width
                                fr_r_reg   <= {1'b0, in_data.frame - base_reg};
                                fr_n_reg   <= in_data.nframes;
                                ret_fr_reg <= S_DONE;
                                state_reg  <= S_FR_TOP;
                            end
                            FN_ALLOC_AT:
                            begin
                                cv_i_reg  <= '0;
                                state_reg <= S_CV_TOP;
                            end
                            FN_INIT:
                            begin
                                fout_reg  <= '0;
                                state_reg <= S_IN_CLR;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                // allocate
                S_AL_START:
                begin
                    if (al_bad)
                    begin
                        status_reg <= ST_BAD_SIZE;
                        fout_reg   <= '0;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        ord_need_reg <= al_ord;
                        f_reg        <= OW1'(al_ord);
                        state_reg    <= S_AL_FIND;
                    end
                end
                S_AL_FIND:
                begin
                    if (f_reg == OW1'(NUM_ORDERS))
                    begin
                        status_reg <= ST_NO_MEM;
                        fout_reg   <= '0;
                        state_reg  <= S_DONE;
                    end
                    else if (count_q == '0 || head_q >= NIL)
                    begin
                        f_reg <= f_reg + OW1'(1);
                    end
                    else
                    begin
                        a_reg       <= AW'(head_q);
                        lst_ord_reg <= OW'(f_reg);
                        lst_n_reg   <= head_q[IW-1:0];
                        ret_lst_reg <= S_AL_CLR;
                        state_reg   <= S_LR_RD;
                    end
                end
                S_AL_CLR:
                begin
                    state_reg <= S_AL_SPLIT;
                end
                S_AL_SPLIT:
                begin
                    if (f_reg > OW1'(ord_need_reg))
                    begin
                        f_reg       <= f_reg - OW1'(1);
                        lst_ord_reg <= f_dn;
                        lst_n_reg   <= al_s_push[IW-1:0];
                        ret_lst_reg <= S_AL_SPLB;
                        state_reg   <= S_LP_WR;
                    end
                    else
                    begin
                        fr_r_reg   <= a_reg + AW'(nreq_reg);
                        fr_n_reg   <= CNT_W'((AW'(1) << ord_need_reg) - AW'(nreq_reg));
                        ret_fr_reg <= S_AL_END;
                        state_reg  <= S_FR_TOP;
                    end
                end
                S_AL_SPLB:
                begin
                    state_reg <= S_AL_SPLIT;
                end
                S_AL_END:
                begin
                    fout_reg  <= base_reg + a_reg[FRAME_W-1:0];
                    state_reg <= S_DONE;
                end

                // free range: aligned chunks, each checked frame by frame, order by order
                S_FR_TOP:
                begin
                    if (fr_n_reg == '0)
                    begin
                        state_reg <= ret_fr_reg;
                    end
                    else
                    begin
                        c_reg <= fr_c;
                        if ((AW+1)'(fr_r_reg) + (AW+1)'(AW'(1) << fr_c) > (AW+1)'(lim))
                        begin
                            state_reg <= S_FR_NEXT;
                        end
                        else
                        begin
                            i_reg     <= '0;
                            k_reg     <= '0;
                            pend_reg  <= 1'b0;
                            last_reg  <= 1'b0;
                            state_reg <= S_FR_SCAN;
                        end
                    end
                end
                S_FR_SCAN:
                begin
                    if (pend_reg && bit_q)
                    begin
                        state_reg <= S_FR_NEXT;
                    end
                    else if (last_reg)
                    begin
                        fb_r_reg   <= fr_r_reg;
                        fb_o_reg   <= c_reg;
                        ret_fb_reg <= S_FR_NEXT;
                        state_reg  <= S_FB_TOP;
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                        if (k_reg == TOP_ORD)
                        begin
                            k_reg <= '0;
                            if (i_reg == fr_sz - AW'(1))
                            begin
                                last_reg <= 1'b1;
                            end
                            else
                            begin
                                i_reg <= i_reg + AW'(1);
                            end
                        end
                        else
                        begin
                            k_reg <= k_reg + OW'(1);
                        end
                    end
                end
                S_FR_NEXT:
                begin
                    fr_r_reg  <= fr_r_reg + fr_sz;
                    fr_n_reg  <= fr_n_reg - CNT_W'(fr_sz);
                    state_reg <= S_FR_TOP;
                end

                // allocate at: carve one frame at a time
                S_CV_TOP:
                begin
                    if (cv_i_reg == nreq_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (AW'(r_reg) + AW'(cv_i_reg) >= lim)
                    begin
                        status_reg <= ST_TAKEN;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        cr_reg    <= AW'(r_reg) + AW'(cv_i_reg);
                        cv_o_reg  <= TOP_ORD;
                        state_reg <= S_CV_FIND;
                    end
                end
                S_CV_FIND:
                begin
                    state_reg <= S_CV_CHK;
                end
                S_CV_CHK:
                begin
                    if (bit_q)
                    begin
                        base_blk_reg <= cv_base;
                        lst_ord_reg  <= cv_o_reg;
                        lst_n_reg    <= cv_base[IW-1:0];
                        ret_lst_reg  <= S_CV_CLR;
                        state_reg    <= S_LR_RD;
                    end
                    else if (cv_o_reg == '0)
                    begin
                        status_reg <= ST_TAKEN;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        cv_o_reg  <= cv_o_dn;
                        state_reg <= S_CV_FIND;
                    end
                end
                S_CV_CLR:
                begin
                    state_reg <= S_CV_SPLIT;
                end
                S_CV_SPLIT:
                begin
                    if (cv_o_reg == '0)
                    begin
                        cv_i_reg  <= cv_i_reg + CNT_W'(1);
                        state_reg <= S_CV_TOP;
                    end
                    else
                    begin
                        // free the half that does not hold the frame
                        cv_o_reg   <= cv_o_dn;
                        fb_o_reg   <= cv_o_dn;
                        ret_fb_reg <= S_CV_SPLIT;
                        state_reg  <= S_FB_TOP;
                        if (cr_reg >= cv_upper)
                        begin
                            fb_r_reg     <= base_blk_reg;
                            base_blk_reg <= cv_upper;
                        end
                        else
                        begin
                            fb_r_reg <= cv_upper;
                        end
                    end
                end

                // init
                S_IN_CLR:
                begin
                    for (int j = 0; j < NUM_ORDERS; j++)
                    begin
                        head_reg[j]  <= NIL;
                        count_reg[j] <= '0;
                    end
                    total_reg <= '0;
                    state_reg <= S_IN_WAIT;
                end
                S_IN_WAIT:
                begin
                    if (!bm_busy)
                    begin
                        fr_r_reg  <= '0;
                        state_reg <= S_IN_TOP;
                    end
                end
                S_IN_TOP:
                begin
                    if (fr_r_reg >= lim)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        c_reg      <= in_o;
                        fb_r_reg   <= fr_r_reg;
                        fb_o_reg   <= in_o;
                        ret_fb_reg <= S_IN_NEXT;
                        state_reg  <= S_FB_TOP;
                    end
                end
                S_IN_NEXT:
                begin
                    fr_r_reg  <= fr_r_reg + fr_sz;
                    state_reg <= S_IN_TOP;
                end

                // free one block, merging upward with free buddies
                S_FB_TOP:
                begin
                    if (bm_ctl.rd)
                    begin
                        state_reg <= S_FB_CHK;
                    end
                    else
                    begin
                        state_reg <= S_FB_PUSH;
                    end
                end
                S_FB_CHK:
                begin
                    if (!bit_q)
                    begin
                        state_reg <= S_FB_PUSH;
                    end
                    else
                    begin
                        lst_ord_reg <= fb_o_reg;
                        lst_n_reg   <= fb_b[IW-1:0];
                        ret_lst_reg <= S_FB_MRG;
                        state_reg   <= S_LR_RD;
                    end
                end
                S_FB_MRG:
                begin
                    if (fb_b < fb_r_reg)
                    begin
                        fb_r_reg <= fb_b;
                    end
                    fb_o_reg  <= fb_o_reg + OW'(1);
                    state_reg <= S_FB_TOP;
                end
                S_FB_PUSH:
                begin
                    lst_ord_reg <= fb_o_reg;
                    lst_n_reg   <= fb_r_reg[IW-1:0];
                    ret_lst_reg <= S_FB_SET;
                    state_reg   <= S_LP_WR;
                end
                S_FB_SET:
                begin
                    state_reg <= ret_fb_reg;
                end

                // list remove
                S_LR_RD:
                begin
                    state_reg <= S_LR_WR;
                end
                S_LR_WR:
                begin
                    if (lk_pv_q >= NIL)
                    begin
                        head_reg[lst_ord_reg] <= lk_nx_q;
                    end
                    if (count_q != '0)
                    begin
                        count_reg[lst_ord_reg] <= count_q - CNT_W'(1);
                    end
                    if (AW'(total_reg) >= lst_one)
                    begin
                        total_reg <= total_reg - CNT_W'(lst_one);
                    end
                    else
                    begin
                        total_reg <= '0;
                    end
                    state_reg <= ret_lst_reg;
                end

                // list push
                S_LP_WR:
                begin
                    state_reg <= S_LP_LINK;
                end
                S_LP_LINK:
                begin
                    head_reg[lst_ord_reg]  <= LW'(lst_n_reg);
                    count_reg[lst_ord_reg] <= count_q + CNT_W'(1);
                    total_reg              <= total_reg + CNT_W'(lst_one);
                    state_reg              <= ret_lst_reg;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_data_reg.status    <= status_reg;
                        out_data_reg.frame_out <= fout_reg;
                        out_data_reg.free_cnt  <= total_reg;
                        state_reg              <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || bm_busy;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/buddy_frame_allocator_top.sv @@
// Buddy frame allocator: sequencer, link memories and free bitmap.
// One transaction at a time; in_stall stays high from acceptance until the result is queued.
// Alloc: searches the orders upward, unlinks the block, splits it down, then frees the tail.
// Free range: up to NUM_ORDERS bitmap reads per frame of each chunk, then merges and a list push.
// Init sweeps 2*MAX_FRAMES+NUM_ORDERS bitmap entries, then frees the region block by block, merging.
// After reset the same bitmap sweep runs with in_stall high; lists start empty.
`default_nettype none
module buddy_frame_allocator_top #(
    parameter int NUM_ORDERS = bfa_pkg::DEF_NUM_ORDERS,
    parameter int MAX_FRAMES = bfa_pkg::DEF_MAX_FRAMES
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  bfa_pkg::bfa_req_t                in_data,
    output logic                             out_valid,
    input  wire                              out_stall,
    output bfa_pkg::bfa_rsp_t                out_data,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [bfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [bfa_pkg::FRAME_W-1:0]       cfg_data
);
    import bfa_pkg::*;

    localparam int IW = $clog2(MAX_FRAMES);
    localparam int LW = IW + 1;
    localparam int BW = $clog2(2 * MAX_FRAMES + NUM_ORDERS);

    link_ctl_t      lk_ctl;
    logic [IW-1:0]  lk_rd_addr;
    logic [IW-1:0]  lk_nx_addr;
    logic [LW-1:0]  lk_nx_wdata;
    logic [IW-1:0]  lk_pv_addr;
    logic [LW-1:0]  lk_pv_wdata;
    logic [LW-1:0]  lk_nx_q;
    logic [LW-1:0]  lk_pv_q;
    bm_ctl_t        bm_ctl;
    logic [BW-1:0]  bm_addr;
    logic           bm_q;
    logic           bm_busy;

    bfa_seq #(
        .NUM_ORDERS (NUM_ORDERS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .lk_ctl      (lk_ctl),
        .lk_rd_addr  (lk_rd_addr),
        .lk_nx_addr  (lk_nx_addr),
        .lk_nx_wdata (lk_nx_wdata),
        .lk_pv_addr  (lk_pv_addr),
        .lk_pv_wdata (lk_pv_wdata),
        .lk_nx_q     (lk_nx_q),
        .lk_pv_q     (lk_pv_q),
        .bm_ctl      (bm_ctl),
        .bm_addr     (bm_addr),
        .bm_q        (bm_q),
        .bm_busy     (bm_busy)
    );

    bfa_links #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_links (
        .clk      (clk),
        .ctl      (lk_ctl),
        .rd_addr  (lk_rd_addr),
        .nx_addr  (lk_nx_addr),
        .nx_wdata (lk_nx_wdata),
        .pv_addr  (lk_pv_addr),
        .pv_wdata (lk_pv_wdata),
        .nx_q     (lk_nx_q),
        .pv_q     (lk_pv_q)
    );

    bfa_bitmap #(
        .NUM_ORDERS (NUM_ORDERS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bm_ctl),
        .addr  (bm_addr),
        .q     (bm_q),
        .busy  (bm_busy)
    );

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("accepted a transaction without going busy");

    a_bad_size_frame: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_BAD_SIZE) |-> (out_data.frame_out == '0)
    ) else $error("bad size result carries a frame");

    a_free_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(out_data.free_cnt) <= MAX_FRAMES)
    ) else $error("free frame total above region size");

endmodule
`default_nettype wire

@@ dv/buddy_frame_allocator_top_test.sv @@
// Self-checking testbench for the buddy frame allocator: directed and random traffic against a predictor.
`default_nettype none
module buddy_frame_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int unsigned ORDERS   = DEF_NUM_ORDERS;
    localparam int unsigned FRAMES   = DEF_MAX_FRAMES;
    localparam int unsigned NIL      = FRAMES;
    localparam int unsigned MAP_SIZE = 2 * FRAMES + ORDERS;
    localparam int unsigned TOP_ORD  = ORDERS - 1;
    localparam int unsigned MASK_F   = 20'hFFFFF;
    localparam int unsigned MASK_C   = 15'h7FFF;
    localparam int          IDLE_LIMIT = 400000;

    class frame_alloc_scoreboard;
        int unsigned base_frame;
        int unsigned region_size;
        int unsigned head[ORDERS];
        int unsigned count[ORDERS];
        int unsigned nxt[FRAMES];
        int unsigned prv[FRAMES];
        bit          free_map[MAP_SIZE];
        int unsigned total;
        int unsigned sec_off[ORDERS];
        bfa_rsp_t    pending[$];
        int          mismatches;
        int          checked;
        int          ops[4];
        int          statuses[4];

        function new();
            int unsigned off;
            off = 0;
            for (int j = 0; j < ORDERS; j++)
            begin
                sec_off[j] = off;
                off += (FRAMES >> j) + 1;
            end
            base_frame  = 0;
            region_size = 16384;
            for (int j = 0; j < ORDERS; j++)
            begin
                head[j]  = NIL;
                count[j] = 0;
            end
            foreach (free_map[i]) free_map[i] = 0;
            total = 0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] data);
            if (idx == CFG_BASE)
                base_frame = data;
            else if (idx == CFG_FRAMES)
                region_size = data & MASK_C;
        endfunction

        function int unsigned limit();
            return region_size > FRAMES ? FRAMES : region_size;
        endfunction

        function bit map_get(input int unsigned o, input int unsigned i);
            int unsigned p;
            p = sec_off[o] + i;
            return p < MAP_SIZE && free_map[p];
        endfunction

        function void map_put(input int unsigned o, input int unsigned i, input bit v);
            int unsigned p;
            p = sec_off[o] + i;
            if (p < MAP_SIZE)
                free_map[p] = v;
        endfunction

        function void push(input int unsigned o, input int unsigned n);
            if (n >= FRAMES || o >= ORDERS)
                return;
            prv[n] = NIL;
            nxt[n] = head[o];
            if (head[o] < FRAMES)
                prv[head[o]] = n;
            head[o]  = n;
            count[o] = (count[o] + 1) & MASK_C;
            total    = (total + (32'd1 << o)) & MASK_C;
        endfunction

        function void unlink(input int unsigned o, input int unsigned n);
            int unsigned p;
            int unsigned x;
            if (n >= FRAMES || o >= ORDERS)
                return;
            p = prv[n];
            x = nxt[n];
            if (p < FRAMES)
                nxt[p] = x;
            else
                head[o] = x;
            if (x < FRAMES)
                prv[x] = p;
            if (count[o] > 0)
                count[o]--;
            total = total >= (32'd1 << o) ? total - (32'd1 << o) : 0;
        endfunction

        // merge upward with free buddies, then list the result
        function void release_block(input int unsigned r, input int unsigned o);
            int unsigned bidx;
            int unsigned b;
            while (o < TOP_ORD)
            begin
                bidx = (r >> o) ^ 1;
                b    = bidx << o;
                if (b + (32'd1 << o) > limit())
                    break;
                if (!map_get(o, bidx))
                    break;
                unlink(o, b);
                map_put(o, bidx, 0);
                if (b < r)
                    r = b;
                o++;
            end
            push(o, r);
            map_put(o, r >> o, 1);
        endfunction

        function bit frame_free(input int unsigned r);
            for (int k = 0; k < ORDERS; k++)
                if (map_get(k, r >> k))
                    return 1;
            return 0;
        endfunction

        function void release_range(input int unsigned r, input int unsigned n);
            int unsigned c;
            int unsigned sz;
            bit ok;
            while (n > 0)
            begin
                c = TOP_ORD;
                while (c > 0 && ((r & ((32'd1 << c) - 1)) != 0 || (32'd1 << c) > n))
                    c--;
                sz = 32'd1 << c;
                ok = r + sz <= limit();
                for (int unsigned i = 0; ok && i < sz; i++)
                    if (frame_free(r + i))
                        ok = 0;
                if (ok)
                    release_block(r, c);
                r += sz;
                n -= sz;
            end
        endfunction

        function bit carve(input int unsigned r);
            int unsigned base;
            int unsigned upper;
            int o;
            if (r >= limit())
                return 0;
            for (int k = ORDERS - 1; k >= 0; k--)
            begin
                base = (r >> k) << k;
                if (map_get(k, r >> k))
                begin
                    unlink(k, base);
                    map_put(k, r >> k, 0);
                    o = k;
                    while (o > 0)
                    begin
                        o--;
                        upper = base + (32'd1 << o);
                        if (r >= upper)
                        begin
                            release_block(base, o);
                            base = upper;
                        end
                        else
                            release_block(upper, o);
                    end
                    return 1;
                end
            end
            return 0;
        endfunction

        function void rebuild();
            int unsigned lim;
            int unsigned r;
            int unsigned o;
            lim = limit();
            r = 0;
            foreach (free_map[i]) free_map[i] = 0;
            for (int j = 0; j < ORDERS; j++)
            begin
                head[j]  = NIL;
                count[j] = 0;
            end
            total = 0;
            while (r < lim)
            begin
                o = TOP_ORD;
                while (o > 0 && (r + (32'd1 << o) > lim || (r & ((32'd1 << o) - 1)) != 0))
                    o--;
                release_block(r, o);
                r += 32'd1 << o;
            end
        endfunction

        function bfa_rsp_t note_request(input bfa_req_t req);
            bfa_rsp_t    rsp;
            int unsigned n;
            int unsigned r;
            int unsigned o;
            int unsigned f;
            int unsigned a;
            rsp_status_t st;
            n  = req.nframes;
            r  = (req.frame - base_frame) & MASK_F;
            st = ST_OK;
            rsp.frame_out = '0;
            case (req.func)
                FN_ALLOC:
                begin
                    o = 0;
                    while (o < ORDERS && (32'd1 << o) < n)
                        o++;
                    if (n == 0 || o >= ORDERS)
                        st = ST_BAD_SIZE;
                    else
                    begin
                        f = o;
                        while (f < ORDERS && (count[f] == 0 || head[f] >= FRAMES))
                            f++;
                        if (f >= ORDERS)
                            st = ST_NO_MEM;
                        else
                        begin
                            a = head[f];
                            unlink(f, a);
                            map_put(f, a >> f, 0);
                            while (f > o)
                            begin
                                f--;
                                push(f, a + (32'd1 << f));
                                map_put(f, (a + (32'd1 << f)) >> f, 1);
                            end
                            release_range(a + n, (32'd1 << o) - n);
                            rsp.frame_out = (base_frame + a) & MASK_F;
                        end
                    end
                end
                FN_FREE:
                begin
                    release_range(r, n);
                    rsp.frame_out = req.frame;
                end
                FN_ALLOC_AT:
                begin
                    for (int unsigned i = 0; i < n; i++)
                        if (!carve(r + i))
                        begin
                            st = ST_TAKEN;
                            break;
                        end
                    rsp.frame_out = req.frame;
                end
                default: rebuild();
            endcase
            rsp.status   = st;
            rsp.free_cnt = total & MASK_C;
            pending.push_back(rsp);
            ops[req.func]++;
            statuses[st]++;
            return rsp;
        endfunction

        task report_mismatch(input string what, input int unsigned got, input int unsigned want);
            mismatches++;
            $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        endtask

        task check_response(input bfa_rsp_t rsp);
            bfa_rsp_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected transaction", rsp.frame_out, 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (rsp.status != want.status)
                report_mismatch("status", rsp.status, want.status);
            if (rsp.frame_out != want.frame_out)
                report_mismatch("frame_out", rsp.frame_out, want.frame_out);
            if (rsp.free_cnt != want.free_cnt)
                report_mismatch("free_cnt", rsp.free_cnt, want.free_cnt);
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    bfa_req_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    bfa_rsp_t             out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FRAME_W-1:0]   cfg_data;

    frame_alloc_scoreboard sb = new();

    int unsigned base_reg;
    int unsigned size_reg;
    int unsigned held_off[$];
    int unsigned held_len[$];
    int          burst_left;
    int          idle_cycles;
    int          stall_mode;
    int          stall_left;
    int          stall_cnt;

    buddy_frame_allocator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // receiver stall pattern: switches among none, random, periodic and long stalls
    initial
    begin
        out_stall  = 0;
        stall_mode = 0;
        stall_left = 300;
        stall_cnt  = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(50, 400);
            end
            stall_left--;
            stall_cnt++;
            case (stall_mode)
                0: out_stall = 0;
                1: out_stall = ($urandom_range(0, 99) < 40);
                2: out_stall = (stall_cnt % 5) < 2;
                default: out_stall = ($urandom_range(0, 99) < 90);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_response(out_data);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_req(input func_t f, input int unsigned fr, input int unsigned n,
                            output bfa_rsp_t want);
        bfa_req_t req;
        req.func    = f;
        req.frame   = fr[19:0];
        req.nframes = n[14:0];
        in_data  = req;
        in_valid = 1;
        do @(posedge clk); while (in_stall);
        want = sb.note_request(req);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid = 0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 20)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    // send one request and keep the list of blocks held by the client up to date
    task automatic issue(input func_t f, input int unsigned fr, input int unsigned n);
        bfa_rsp_t want;
        send_req(f, fr, n, want);
        if (f == FN_ALLOC && want.status == ST_OK)
        begin
            held_off.push_back((want.frame_out - base_reg) & MASK_F);
            held_len.push_back(n);
        end
        else if (f == FN_ALLOC_AT && want.status == ST_OK && n > 0)
        begin
            held_off.push_back((fr - base_reg) & MASK_F);
            held_len.push_back(n);
        end
        else if (f == FN_INIT)
        begin
            held_off.delete();
            held_len.delete();
        end
    endtask

    task automatic drain();
        in_valid = 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        cfg_index = idx;
        cfg_data  = data[19:0];
        cfg_valid = 1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, data[19:0]);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic configure(input int unsigned base, input int unsigned frames);
        drain();
        repeat (100) @(negedge clk);
        write_reg(CFG_BASE, base);
        write_reg(CFG_FRAMES, frames);
        base_reg = base & MASK_F;
        size_reg = (frames & MASK_C) > FRAMES ? FRAMES : (frames & MASK_C);
        issue(FN_INIT, 0, 0);
    endtask

    function automatic int unsigned abs_frame(input int unsigned r);
        return (base_reg + r) & MASK_F;
    endfunction

    task automatic random_item();
        int unsigned pick;
        int unsigned n;
        int unsigned r;
        int          k;
        pick = $urandom_range(0, 999);
        if (pick < 3)
            issue(FN_INIT, $urandom, $urandom_range(0, 7));
        else if (pick < 360)
        begin
            k = $urandom_range(0, 99);
            if (k < 1)
                n = $urandom_range(65, 1024);
            else if (k < 3)
                n = $urandom_range(0, MASK_C);
            else if (k < 60)
                n = $urandom_range(1, 8);
            else
                n = $urandom_range(1, 64);
            issue(FN_ALLOC, $urandom, n);
        end
        else if (pick < 680 && held_off.size() > 0)
        begin
            k = $urandom_range(0, held_off.size() - 1);
            r = held_off[k];
            n = held_len[k];
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n);
            else
            begin
                held_off.delete(k);
                held_len.delete(k);
            end
            issue(FN_FREE, abs_frame(r), n);
        end
        else if (pick < 850)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // wild frame; long counts only when the first frame is outside the region
                r = $urandom & MASK_F;
                n = ((r - base_reg) & MASK_F) >= size_reg ? $urandom_range(0, MASK_C)
                                                          : $urandom_range(0, 4);
                issue(FN_ALLOC_AT, r, n);
            end
            else
                issue(FN_ALLOC_AT, abs_frame($urandom_range(0, size_reg - 1)),
                      $urandom_range(1, 8));
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
                issue(FN_FREE, $urandom & MASK_F, $urandom_range(1, 4));
            else
                issue(FN_FREE, abs_frame($urandom_range(0, size_reg - 1)),
                      $urandom_range(1, 32));
        end
    endtask

    int unsigned phase_base[6] = '{0, 20'hFFFFF, 20'h40000, 20'hABC00, 0, 20'h00400};
    int unsigned phase_size[6] = '{16384, 16384, 32767, 5000, 0, 3};

    initial
    begin
        rst_n      = 0;
        in_valid   = 0;
        in_data    = '0;
        cfg_valid  = 0;
        cfg_index  = CFG_BASE;
        cfg_data   = '0;
        idle_cycles = 0;
        burst_left = 1;
        base_reg   = 0;
        size_reg   = FRAMES;
        repeat (12) @(negedge clk);
        rst_n = 1;

        // directed part
        configure(0, 16384);
        issue(FN_ALLOC, 0, 0);
        issue(FN_ALLOC, 0, MASK_C);
        issue(FN_ALLOC, 0, 1025);
        issue(FN_ALLOC, 0, 1024);
        issue(FN_ALLOC, 0, 1);
        issue(FN_ALLOC, 0, 3);
        issue(FN_FREE, abs_frame(held_off[held_off.size() - 1]), 3);
        issue(FN_FREE, abs_frame(held_off[held_off.size() - 1]), 3);
        issue(FN_FREE, MASK_F, 2);
        issue(FN_ALLOC_AT, 5000, 0);
        issue(FN_ALLOC_AT, 5000, 4);
        issue(FN_ALLOC_AT, 5002, 4);
        issue(FN_ALLOC_AT, MASK_F, 1);
        issue(FN_FREE, 0, 2048);
        issue(FN_ALLOC_AT, 16383, 3);
        issue(FN_FREE, 16383, 1);
        configure(0, 1);
        issue(FN_ALLOC, 0, 1);
        issue(FN_ALLOC, 0, 1);
        issue(FN_FREE, 0, 1);
        issue(FN_ALLOC, 0, 2);

        phase_size[4] = $urandom_range(1, 16384);
        phase_base[4] = $urandom & MASK_F;
        for (int p = 0; p < 6; p++)
        begin
            configure(phase_base[p], phase_size[p]);
            for (int i = 0; i < 305; i++)
            begin
                if (i == 150)
                    drain();
                random_item();
            end
        end

        drain();
        repeat (200) @(negedge clk);
        if (sb.pending.size() != 0)
            sb.report_mismatch("missing transactions", 0, sb.pending.size());
        $display("covered %0d alloc, %0d free, %0d alloc-at, %0d init over 8 region settings",
                 sb.ops[FN_ALLOC], sb.ops[FN_FREE], sb.ops[FN_ALLOC_AT], sb.ops[FN_INIT]);
        $display("results checked %0d: ok %0d, bad size %0d, no memory %0d, taken %0d",
                 sb.checked, sb.statuses[ST_OK], sb.statuses[ST_BAD_SIZE],
                 sb.statuses[ST_NO_MEM], sb.statuses[ST_TAKEN]);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
